@@ src/kct_pkg.sv @@
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants for the keyed count table.
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int SLOTS     = 32;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int KEY_W     = 16;
    localparam int CNT_W     = 16;
    localparam int USED_W    = $clog2(SLOTS + 1);
    localparam int SLOT_IN_W = 5;

    localparam logic [KEY_W-1:0] KEY_EMPTY = '0;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

endpackage

@@ src/keyed_count_table_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_count_table_unit
// Slot table of key/count pairs kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// Add/remove/contains do one RAM read per slot for the scan, then pass
//   through ST_WRITE (a write-back for add/remove) to the o_valid strobe.
// Read: RAM read, then ST_READ; other blank-key requests fail on accept.
// One request at a time; o_busy high until the strobe (low for blank keys).
// Reset clears per-slot valid flops at once, so all slots read blank at once.
// The result is shown for one cycle only; the receiver cannot stall it.
module keyed_count_table_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_command,
    input  logic [kct_pkg::KEY_W-1:0]      i_item_key,
    input  logic [kct_pkg::CNT_W-1:0]      i_amount,
    input  logic [kct_pkg::SLOT_IN_W-1:0]  i_slot_index,
    output logic                           o_valid,
    output logic                           o_ok,
    output logic [kct_pkg::KEY_W-1:0]      o_read_key,
    output logic [kct_pkg::CNT_W-1:0]      o_read_count,
    output logic [kct_pkg::USED_W-1:0]     o_used_slots
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_READ
    } t_state;

    t_state                         r_state, n_state;
    kct_pkg::t_cmd                  r_cmd, n_cmd;
    logic [kct_pkg::KEY_W-1:0]      r_key, n_key;
    logic [kct_pkg::CNT_W-1:0]      r_amt, n_amt;
    logic                           r_in_range, n_in_range;
    logic [kct_pkg::IDX_W-1:0]      r_addr, n_addr;
    logic                           r_found, n_found;
    logic [kct_pkg::IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [kct_pkg::CNT_W-1:0]      r_hit_cnt, n_hit_cnt;
    logic                           r_blank_found, n_blank_found;
    logic [kct_pkg::IDX_W-1:0]      r_blank_idx, n_blank_idx;
    logic [kct_pkg::USED_W-1:0]     r_used, n_used;
    logic                           r_valid, n_valid;
    logic                           r_ok, n_ok;
    logic [kct_pkg::KEY_W-1:0]      r_read_key, n_read_key;
    logic [kct_pkg::CNT_W-1:0]      r_read_count, n_read_count;

    // slot storage and read port
    kct_pkg::t_entry                r_mem [kct_pkg::SLOTS];
    logic [kct_pkg::SLOTS-1:0]      r_slot_valid;
    kct_pkg::t_entry                r_rd_data;
    logic                           r_rd_valid;

    logic                           rd_en;
    logic [kct_pkg::IDX_W-1:0]      rd_addr;
    logic                           wr_en;
    logic [kct_pkg::IDX_W-1:0]      wr_addr;
    kct_pkg::t_entry                wr_data;

    logic [kct_pkg::KEY_W-1:0]      scan_key;
    logic [kct_pkg::CNT_W-1:0]      scan_cnt;
    logic [kct_pkg::CNT_W:0]        sum;
    kct_pkg::t_cmd                  in_cmd;

    assign in_cmd   = kct_pkg::t_cmd'(i_command);
    // a slot never written reads as blank
    assign scan_key = r_rd_valid ? r_rd_data.key   : kct_pkg::KEY_EMPTY;
    assign scan_cnt = r_rd_valid ? r_rd_data.count : '0;
    assign sum      = {1'b0, r_hit_cnt} + {1'b0, r_amt};

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_key         = r_key;
        n_amt         = r_amt;
        n_in_range    = r_in_range;
        n_addr        = r_addr;
        n_found       = r_found;
        n_hit_idx     = r_hit_idx;
        n_hit_cnt     = r_hit_cnt;
        n_blank_found = r_blank_found;
        n_blank_idx   = r_blank_idx;
        n_used        = r_used;
        n_valid       = 1'b0;
        n_ok          = r_ok;
        n_read_key    = r_read_key;
        n_read_count  = r_read_count;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = r_hit_idx;
        wr_data       = '{key: r_key, count: r_hit_cnt};

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd         = in_cmd;
                    n_key         = i_item_key;
                    n_amt         = i_amount;
                    n_in_range    = 32'(i_slot_index) < kct_pkg::SLOTS;
                    n_found       = 1'b0;
                    n_blank_found = 1'b0;
                    n_addr        = '0;
                    if (in_cmd == kct_pkg::CMD_READ) begin
                        rd_en   = 1'b1;
                        rd_addr = i_slot_index[kct_pkg::IDX_W-1:0];
                        n_state = ST_READ;
                    end else if (i_item_key == kct_pkg::KEY_EMPTY) begin
                        // blank key: fail at once, table unchanged
                        n_valid      = 1'b1;
                        n_ok         = 1'b0;
                        n_read_key   = '0;
                        n_read_count = '0;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // data for slot r_addr is on the read port
                if (!r_found && scan_key == r_key) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_addr;
                    n_hit_cnt = scan_cnt;
                end
                if (!r_blank_found && scan_key == kct_pkg::KEY_EMPTY) begin
                    n_blank_found = 1'b1;
                    n_blank_idx   = r_addr;
                end
                if (32'(r_addr) == kct_pkg::SLOTS - 1) begin
                    n_state = ST_WRITE;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = r_addr + 1'b1;
                end
            end

            ST_WRITE: begin
                n_valid      = 1'b1;
                n_ok         = 1'b0;
                n_read_key   = '0;
                n_read_count = '0;
                n_state      = ST_IDLE;
                unique case (r_cmd)
                    kct_pkg::CMD_ADD: begin
                        if (r_found) begin
                            wr_en         = 1'b1;
                            wr_data.count = sum[kct_pkg::CNT_W] ? kct_pkg::CNT_MAX
                                                               : sum[kct_pkg::CNT_W-1:0];
                            n_ok          = 1'b1;
                        end else if (r_blank_found) begin
                            wr_en   = 1'b1;
                            wr_addr = r_blank_idx;
                            wr_data = '{key: r_key, count: r_amt};
                            n_used  = r_used + 1'b1;
                            n_ok    = 1'b1;
                        end
                    end
                    kct_pkg::CMD_REMOVE: begin
                        if (r_found && r_hit_cnt > r_amt) begin
                            wr_en         = 1'b1;
                            wr_data.count = r_hit_cnt - r_amt;
                            n_ok          = 1'b1;
                        end else if (r_found && r_hit_cnt == r_amt) begin
                            // exact match: drop the slot back to blank
                            wr_en   = 1'b1;
                            wr_data = '{key: kct_pkg::KEY_EMPTY, count: '0};
                            if (r_used != '0) begin
                                n_used = r_used - 1'b1;
                            end
                            n_ok    = 1'b1;
                        end
                    end
                    kct_pkg::CMD_CONTAINS: begin
                        n_ok = r_found;
                    end
                    kct_pkg::CMD_READ: begin
                        n_ok = 1'b0;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end

            ST_READ: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
                if (r_in_range) begin
                    n_read_key   = scan_key;
                    n_read_count = scan_cnt;
                    n_ok         = scan_key != kct_pkg::KEY_EMPTY;
                end else begin
                    n_read_key   = '0;
                    n_read_count = '0;
                    n_ok         = 1'b0;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_valid <= n_valid;
        end
        r_cmd         <= n_cmd;
        r_key         <= n_key;
        r_amt         <= n_amt;
        r_in_range    <= n_in_range;
        r_addr        <= n_addr;
        r_found       <= n_found;
        r_hit_idx     <= n_hit_idx;
        r_hit_cnt     <= n_hit_cnt;
        r_blank_found <= n_blank_found;
        r_blank_idx   <= n_blank_idx;
        r_ok          <= n_ok;
        r_read_key    <= n_read_key;
        r_read_count  <= n_read_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (wr_en) begin
            r_slot_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data  <= r_mem[rd_addr];
            r_rd_valid <= r_slot_valid[rd_addr];
        end
    end

    assign o_busy       = r_state != ST_IDLE;
    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_read_key   = r_read_key;
    assign o_read_count = r_read_count;
    assign o_used_slots = r_used;

`ifndef SYNTH
    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == ST_IDLE)
        else $error("result strobe while a request is in flight");

    a_write_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WRITE |=> r_valid)
        else $error("write-back cycle did not produce a result");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= kct_pkg::SLOTS)
        else $error("used slot count above table size");

    a_used_vs_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= $countones(r_slot_valid))
        else $error("used slot count exceeds slots ever written");

    a_scan_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN && n_state == ST_SCAN |=> r_addr == $past(r_addr) + 1'b1)
        else $error("scan address did not advance");
`endif

endmodule
